// ----- rtl/core/sast_pkg.sv -----
// Shared constants, codes and types of the sorted address set table.
`timescale 1ns / 1ps

package sast_pkg;

    localparam int CAPACITY = 64;

    localparam int ADDR_W   = 16;
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [OP_W-1:0] OP_QUERY  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_EDIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_CMP,
        ACT_INS,
        ACT_DEL
    } cell_act_t;

    typedef struct packed {
        cell_act_t         act;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  idx;
    } cell_cmd_t;

endpackage

// ----- rtl/core/sorted_address_set_table_top.sv -----
// Top level of the sorted address set table: the chain of cells and its sequencer.
`timescale 1ns / 1ps
// A result word shows on done after its request passes the compare and execute states; an edit
// that moves an entry passes both twice, since the removal shift and the insert shift each need
// a compare step and a shift step through the cell chain. A new word may be accepted in the
// cycle in which the previous request finishes. Results cannot be stalled by the receiver.
// Reset clears the entry count, all valid flags and the sequencer; entry contents are left as
// they are and are never visible until written.

module sorted_address_set_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sast_pkg::OP_W-1:0]     op,
    input  logic [sast_pkg::ADDR_W-1:0]   address,
    input  logic [sast_pkg::INDEX_W-1:0]  index,
    output logic                          done,
    output logic [sast_pkg::STATUS_W-1:0] status,
    output logic                          found,
    output logic [sast_pkg::POS_W-1:0]    position,
    output logic [sast_pkg::ADDR_W-1:0]   read_address,
    output logic [sast_pkg::POS_W-1:0]    entry_count
);
    import sast_pkg::*;

    // Every cell sees the same command. In the compare cycle each cell flags a match, an entry
    // greater than the address, and whether it sits at or beyond the requested index. In the
    // following cycle those flags steer a one-place shift right (insert) or left (remove),
    // so entries stay ascending and packed at the low end of the chain.
    cell_cmd_t                        cmd;
    logic [CAPACITY-1:0][ADDR_W-1:0]  data_w;
    logic [CAPACITY-1:0][ADDR_W-1:0]  rd_terms;
    logic [CAPACITY-1:0]              valid_w;
    logic [CAPACITY-1:0]              gt_w;
    logic [CAPACITY-1:0]              eq_w;
    logic [CAPACITY-1:0]              sel_w;
    logic [CAPACITY-1:0]              ins_w;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [ADDR_W-1:0] left_data;
            logic              left_valid;
            logic              left_gt;
            logic [ADDR_W-1:0] right_data;
            logic              right_valid;

            // The chain's left end acts as a held entry no greater than any address, and its
            // right end as an empty entry.
            if (g == 0)
            begin : g_left_end
                assign left_data  = '0;
                assign left_valid = 1'b1;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_left
                assign left_data  = data_w[g-1];
                assign left_valid = valid_w[g-1];
                assign left_gt    = gt_w[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_right_end
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_right
                assign right_data  = data_w[g+1];
                assign right_valid = valid_w[g+1];
            end

            sast_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cell_id     (IDX_W'(g)),
                .cmd         (cmd),
                .left_data   (left_data),
                .left_valid  (left_valid),
                .left_gt     (left_gt),
                .right_data  (right_data),
                .right_valid (right_valid),
                .data        (data_w[g]),
                .valid       (valid_w[g]),
                .gt          (gt_w[g]),
                .eq          (eq_w[g]),
                .sel         (sel_w[g]),
                .ins_here    (ins_w[g]),
                .rd_term     (rd_terms[g])
            );
        end
    endgenerate

    // The sequencer reduces the cell flags, keeps the entry count and registers each result.
    sast_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .address      (address),
        .index        (index),
        .eq_vec       (eq_w),
        .sel_vec      (sel_w),
        .ins_vec      (ins_w),
        .rd_terms     (rd_terms),
        .cmd          (cmd),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .found        (found),
        .position     (position),
        .read_address (read_address),
        .entry_count  (entry_count)
    );

endmodule

// ----- rtl/core/sast_cell.sv -----
// One cell of the table: holds one entry, compares it and shifts it to a neighbor.
`timescale 1ns / 1ps

module sast_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sast_pkg::IDX_W-1:0]  cell_id,
    input  sast_pkg::cell_cmd_t         cmd,
    input  logic [sast_pkg::ADDR_W-1:0] left_data,
    input  logic                        left_valid,
    input  logic                        left_gt,
    input  logic [sast_pkg::ADDR_W-1:0] right_data,
    input  logic                        right_valid,
    output logic [sast_pkg::ADDR_W-1:0] data,
    output logic                        valid,
    output logic                        gt,
    output logic                        eq,
    output logic                        sel,
    output logic                        ins_here,
    output logic [sast_pkg::ADDR_W-1:0] rd_term
);
    import sast_pkg::*;

    logic [ADDR_W-1:0] data_reg, data_next;
    logic              valid_reg, valid_next;
    logic              eq_reg, eq_next;
    logic              gt_reg, gt_next;
    logic              sel_reg, sel_next;
    logic              ge_reg, ge_next;
    logic              take_addr;

    // The new address lands in the first entry above it, or in the first free one.
    assign take_addr = gt_reg | (!valid_reg && left_valid);

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        eq_next    = eq_reg;
        gt_next    = gt_reg;
        sel_next   = sel_reg;
        ge_next    = ge_reg;
        unique case (cmd.act)
            ACT_HOLD:
            begin
            end
            ACT_CMP:
            begin
                eq_next  = valid_reg && (data_reg == cmd.addr);
                gt_next  = valid_reg && (cmd.addr < data_reg);
                sel_next = (CNT_W'(cell_id) == cmd.idx);
                ge_next  = (CNT_W'(cell_id) >= cmd.idx);
            end
            ACT_INS:
            begin
                if (left_gt)
                begin
                    data_next  = left_data;
                    valid_next = left_valid;
                end
                else if (take_addr)
                begin
                    data_next  = cmd.addr;
                    valid_next = 1'b1;
                end
            end
            ACT_DEL:
            begin
                if (ge_reg)
                begin
                    data_next  = right_data;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            eq_reg    <= 1'b0;
            gt_reg    <= 1'b0;
            sel_reg   <= 1'b0;
            ge_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            eq_reg    <= eq_next;
            gt_reg    <= gt_next;
            sel_reg   <= sel_next;
            ge_reg    <= ge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign gt       = gt_reg;
    assign eq       = eq_reg;
    assign sel      = sel_reg;
    assign ins_here = !left_gt && take_addr;
    assign rd_term  = sel_reg ? data_reg : '0;

endmodule

// ----- rtl/core/sast_ctrl.sv -----
// Sequencer of the table: takes requests, drives the cells and forms each result word.
`timescale 1ns / 1ps

module sast_ctrl (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             start,
    input  logic [sast_pkg::OP_W-1:0]                        op,
    input  logic [sast_pkg::ADDR_W-1:0]                      address,
    input  logic [sast_pkg::INDEX_W-1:0]                     index,
    input  logic [sast_pkg::CAPACITY-1:0]                    eq_vec,
    input  logic [sast_pkg::CAPACITY-1:0]                    sel_vec,
    input  logic [sast_pkg::CAPACITY-1:0]                    ins_vec,
    input  logic [sast_pkg::CAPACITY-1:0][sast_pkg::ADDR_W-1:0] rd_terms,
    output sast_pkg::cell_cmd_t                              cmd,
    output logic                                             busy,
    output logic                                             done,
    output logic [sast_pkg::STATUS_W-1:0]                    status,
    output logic                                             found,
    output logic [sast_pkg::POS_W-1:0]                       position,
    output logic [sast_pkg::ADDR_W-1:0]                      read_address,
    output logic [sast_pkg::POS_W-1:0]                       entry_count
);
    import sast_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 found_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [ADDR_W-1:0]    rd_reg;

    logic                 accept;
    logic                 finish;
    logic                 found_any;
    logic                 hit;
    logic                 in_range;
    logic                 full;
    logic [IDX_W-1:0]     ins_pos;
    logic [ADDR_W-1:0]    rd_data;
    logic                 edit_move;
    logic [STATUS_W-1:0]  status_next;
    logic                 found_next;
    logic [POS_W-1:0]     pos_next;
    logic [ADDR_W-1:0]    rd_next;
    logic [CNT_W-1:0]     count_next;
    cell_act_t            act_next;

    // Reductions over the registered per-cell flags.
    always_comb
    begin
        rd_data = '0;
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_data = rd_data | rd_terms[i];
            if (ins_vec[i])
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
        end
    end

    assign found_any = |eq_vec;
    assign hit       = |(eq_vec & sel_vec);
    assign in_range  = CNT_W'(idx_reg) < count_reg;
    assign full      = count_reg == CNT_W'(CAPACITY);

    // An edit to a different address removes the entry first, then inserts.
    assign edit_move = (op_reg == OP_EDIT) && in_range && !hit;

    always_comb
    begin
        status_next = ST_OK;
        found_next  = 1'b0;
        pos_next    = '0;
        rd_next     = '0;
        count_next  = count_reg;
        act_next    = ACT_HOLD;
        unique case (op_reg)
            OP_QUERY:
            begin
                found_next = found_any;
            end
            OP_INSERT:
            begin
                if (found_any)
                begin
                    status_next = ST_DUP;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    act_next   = ACT_INS;
                    pos_next   = POS_W'(ins_pos);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    act_next   = ACT_DEL;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_EDIT:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else if (hit)
                begin
                    pos_next = POS_W'(idx_reg);
                end
                else
                begin
                    act_next   = ACT_DEL;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (!in_range)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_next  = rd_data;
                    pos_next = POS_W'(idx_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign finish = (state_reg == S_EXEC) && !edit_move;
    assign busy   = (state_reg == S_CMP) || ((state_reg == S_EXEC) && !finish);
    assign accept = start && !busy;

    always_comb
    begin
        cmd.addr = addr_reg;
        cmd.idx  = CNT_W'(idx_reg);
        unique case (state_reg)
            S_CMP:   cmd.act = ACT_CMP;
            S_EXEC:  cmd.act = act_next;
            default: cmd.act = ACT_HOLD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_QUERY;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            rd_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (state_reg == S_EXEC)
            begin
                count_reg <= count_next;
            end
            if (edit_move && (state_reg == S_EXEC))
            begin
                op_reg    <= OP_INSERT;
                state_reg <= S_CMP;
            end
            else
            begin
                if (finish)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= status_next;
                    found_reg  <= found_next;
                    pos_reg    <= pos_next;
                    rd_reg     <= rd_next;
                end
                unique case (state_reg)
                    S_IDLE:  state_reg <= accept ? S_CMP : S_IDLE;
                    S_CMP:   state_reg <= S_EXEC;
                    S_EXEC:  state_reg <= accept ? S_CMP : S_IDLE;
                    default: state_reg <= S_IDLE;
                endcase
                if (accept)
                begin
                    op_reg <= op;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= address;
            idx_reg  <= index;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign position     = pos_reg;
    assign read_address = rd_reg;
    assign entry_count  = POS_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result words closer than two cycles");

    a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EXEC) && (act_next == ACT_INS)) |-> $onehot(ins_vec))
        else $error("insert position is not unique");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("entry count changed outside execution");

endmodule

// ----- test/sorted_address_set_table_top_tb.sv -----
// Self-checking testbench for the sorted address set table: shadow table predictor and result checker.
`timescale 1ns / 1ps

module sorted_address_set_table_top_tb;

    import sast_pkg::*;

    // A result arrives once its request has passed the compare and execute states; an edit
    // that moves an entry passes both twice. The settle time at the end covers the slower case with margin.
    localparam int SETTLE_CYCLES = 8;

    // Sender pauses and the time the block takes per request are both bounded, so a
    // correct run never goes this long without accepting a request word or a result word.
    localparam int QUIET_LIMIT = 500;

    localparam int MISMATCH_SHOWN = 10;

    // One expected result word, one member for each result port.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [ADDR_W-1:0]   read_address;
        logic [POS_W-1:0]    entry_count;
    } table_answer_t;

    logic                clk;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic [OP_W-1:0]     op      = OP_QUERY;
    logic [ADDR_W-1:0]   address = '0;
    logic [INDEX_W-1:0]  index   = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [ADDR_W-1:0]   read_address;
    logic [POS_W-1:0]    entry_count;

    // Shadow copy of the table: ascending entries 0..shadow_count-1.
    logic [ADDR_W-1:0] shadow_table [CAPACITY];
    int                shadow_count = 0;

    // Result words still owed by the block, oldest first.
    table_answer_t pending_answers [$];

    int failures      = 0;
    int mismatches    = 0;
    int answers_seen  = 0;

    // Chance in percent that the sender idles before a request word.
    int pause_pct = 0;

    sorted_address_set_table_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .address      (address),
        .index        (index),
        .done         (done),
        .status       (status),
        .found        (found),
        .position     (position),
        .read_address (read_address),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------------------
    // Predictor. These functions keep the shadow table in step with the block: every
    // accepted request word is applied here in acceptance order, and the answer it must
    // produce is queued for the checker.
    // ------------------------------------------------------------------------------------

    function automatic bit table_holds(input logic [ADDR_W-1:0] a);
        for (int k = 0; k < shadow_count; k++)
            if (shadow_table[k] == a)
                return 1'b1;
        return 1'b0;
    endfunction

    // Sorted insert. The duplicate test wins over the full test. On success "at" is the
    // slot taken, which is just before the first entry greater than the new address.
    function automatic logic [STATUS_W-1:0] table_put(input logic [ADDR_W-1:0] a,
                                                      output int at);
        int k;
        at = 0;
        if (table_holds(a))
            return ST_DUP;
        if (shadow_count >= CAPACITY)
            return ST_FULL;
        k = 0;
        while (k < shadow_count && a >= shadow_table[k])
            k++;
        for (int j = shadow_count; j > k; j--)
            shadow_table[j] = shadow_table[j - 1];
        shadow_table[k] = a;
        shadow_count++;
        at = k;
        return ST_OK;
    endfunction

    // Removes one entry and closes the gap behind it.
    function automatic void table_drop(input int at);
        for (int j = at; j + 1 < shadow_count; j++)
            shadow_table[j] = shadow_table[j + 1];
        shadow_count--;
    endfunction

    function automatic table_answer_t predict_answer(input logic [OP_W-1:0]    o,
                                                     input logic [ADDR_W-1:0]  a,
                                                     input logic [INDEX_W-1:0] i);
        table_answer_t ans;
        int            at;
        int            slot;
        ans  = '0;
        at   = 0;
        slot = int'(i);
        case (o)
            OP_QUERY:
                ans.found = table_holds(a);
            OP_INSERT:
                ans.status = table_put(a, at);
            OP_REMOVE:
                if (slot >= shadow_count)
                    ans.status = ST_RANGE;
                else
                    table_drop(slot);
            OP_EDIT:
                if (slot >= shadow_count)
                    ans.status = ST_RANGE;
                else if (shadow_table[slot] == a)
                    at = slot;
                else
                begin
                    // The old entry goes first; a duplicate then leaves it gone.
                    table_drop(slot);
                    ans.status = table_put(a, at);
                end
            OP_READ:
                if (slot >= shadow_count)
                    ans.status = ST_RANGE;
                else
                begin
                    ans.read_address = shadow_table[slot];
                    at = slot;
                end
            default:
                ;
        endcase
        ans.position    = POS_W'(at);
        ans.entry_count = POS_W'(shadow_count);
        return ans;
    endfunction

    // ------------------------------------------------------------------------------------
    // Sender. A request word is presented with start high and held until an edge at which
    // busy is low. Start stays high after acceptance, so back-to-back words need no
    // extra assignment; a random pause lowers it first.
    // ------------------------------------------------------------------------------------

    task automatic send_word(input logic [OP_W-1:0]    o,
                             input logic [ADDR_W-1:0]  a,
                             input logic [INDEX_W-1:0] i);
        if (pause_pct > 0 && $urandom_range(1, 100) <= pause_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        op      <= o;
        address <= a;
        index   <= i;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_answers.push_back(predict_answer(o, a, i));
    endtask

    // ------------------------------------------------------------------------------------
    // Checker. Result words cannot be held off, so every edge with done high carries one,
    // and it must match the oldest outstanding prediction field by field.
    // ------------------------------------------------------------------------------------

    always @(posedge clk)
    begin : check_answers
        table_answer_t want;
        table_answer_t got;
        if (rst_n && done)
        begin
            answers_seen++;
            got = '{status, found, position, read_address, entry_count};
            if (pending_answers.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN)
                    $display("result %0d arrived with none outstanding: status=%0d found=%0d pos=%0d rd=%h count=%0d",
                             answers_seen, got.status, got.found, got.position,
                             got.read_address, got.entry_count);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.position !== want.position || got.read_address !== want.read_address ||
                    got.entry_count !== want.entry_count)
                begin
                    failures++;
                    mismatches++;
                    if (mismatches <= MISMATCH_SHOWN)
                        $display("result %0d differs: expected status=%0d found=%0d pos=%0d rd=%h count=%0d, got status=%0d found=%0d pos=%0d rd=%h count=%0d",
                                 answers_seen, want.status, want.found, want.position,
                                 want.read_address, want.entry_count, got.status, got.found,
                                 got.position, got.read_address, got.entry_count);
                end
            end
        end
    end

    // Watchdog: a hung block or a lost handshake ends the run here.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------------------

    // An address that is not in the table; only called while the table has room to miss.
    function automatic logic [ADDR_W-1:0] fresh_address();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        while (table_holds(a))
            a = ADDR_W'($urandom);
        return a;
    endfunction

    // One random request word. Addresses mix the full range, a narrow band that makes
    // repeats likely, the two extremes and entries already held, so duplicates, hits and
    // same-address edits all occur. Indexes are mostly valid, sometimes anywhere.
    task automatic random_word(input int insert_pct);
        logic [OP_W-1:0]    o;
        logic [ADDR_W-1:0]  a;
        logic [INDEX_W-1:0] i;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < insert_pct)
            o = OP_INSERT;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
                o = OP_QUERY;
            else if (r < 48)
                o = OP_REMOVE;
            else if (r < 74)
                o = OP_EDIT;
            else if (r < 97)
                o = OP_READ;
            else
                o = OP_W'($urandom_range(OP_READ + 1, 2 ** OP_W - 1));
        end

        if (shadow_count > 0 && $urandom_range(0, 99) < 85)
            i = INDEX_W'($urandom_range(0, shadow_count - 1));
        else
            i = INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));

        r = $urandom_range(0, 9);
        if (r < 4)
            a = ADDR_W'($urandom);
        else if (r < 7)
            a = ADDR_W'($urandom_range(0, 127));
        else if (r == 7)
            a = $urandom_range(0, 1) ? '1 : '0;
        else if (shadow_count > 0)
            a = shadow_table[$urandom_range(0, shadow_count - 1)];
        else
            a = ADDR_W'($urandom);

        // Edits often rewrite the entry with its own value.
        if (o == OP_EDIT && int'(i) < shadow_count && $urandom_range(0, 2) == 0)
            a = shadow_table[i];

        send_word(o, a, i);
    endtask

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // Hand-picked cases on a nearly empty table: range errors on an empty table, the spare
    // op codes, inserts into an empty table, at the front and at the back, a duplicate insert, hits
    // and misses, edits that keep, move and collide, and removals down to empty.
    task automatic test_directed_cases();
        pause_pct = 30;
        send_word(OP_READ,   16'h0000, '0);
        send_word(OP_REMOVE, 16'h0000, '0);
        send_word(OP_EDIT,   16'h1111, '0);
        send_word(OP_QUERY,  16'h0000, '0);
        for (int k = 1; k <= 3; k++)
            send_word(OP_READ + OP_W'(k), '1, '1);
        send_word(OP_INSERT, 16'h8000, '1);
        send_word(OP_INSERT, 16'h0000, '0);
        send_word(OP_INSERT, 16'hFFFF, '0);
        send_word(OP_INSERT, 16'h8000, '0);
        send_word(OP_QUERY,  16'hFFFF, '0);
        send_word(OP_QUERY,  16'h1234, '0);
        send_word(OP_READ,   16'h0000, 6'd2);
        send_word(OP_READ,   16'h0000, '1);
        send_word(OP_READ,   16'h0000, 6'd3);
        send_word(OP_EDIT,   16'h8000, 6'd1);
        send_word(OP_EDIT,   16'h4000, 6'd1);
        send_word(OP_EDIT,   16'hFFFF, 6'd0);
        send_word(OP_REMOVE, 16'h0000, 6'd1);
        send_word(OP_REMOVE, 16'h0000, 6'd5);
        send_word(OP_REMOVE, 16'h0000, 6'd0);
        send_word(OP_READ,   16'h0000, 6'd0);
    endtask

    // Fills the table to capacity, then probes it: a new address is refused as full, a
    // held one as a duplicate, and edits at both ends must work on a full table.
    task automatic test_full_table();
        pause_pct = 20;
        while (shadow_count < CAPACITY)
            send_word(OP_INSERT, ADDR_W'($urandom), INDEX_W'($urandom));
        send_word(OP_INSERT, fresh_address(), '0);
        send_word(OP_INSERT, shadow_table[$urandom_range(0, CAPACITY - 1)], '0);
        send_word(OP_READ,   '0, INDEX_W'(CAPACITY - 1));
        send_word(OP_EDIT,   fresh_address(), INDEX_W'(CAPACITY - 1));
        send_word(OP_EDIT,   shadow_table[0], '0);
        send_word(OP_EDIT,   shadow_table[1], '0);
        send_word(OP_INSERT, fresh_address(), '1);
        send_word(OP_QUERY,  shadow_table[CAPACITY / 2], '0);
        for (int k = 0; k < 6; k++)
            random_word(50);
    endtask

    // The bulk of the run: phases that lean toward growing or shrinking the table, with
    // different pause rates, including stretches with none.
    task automatic test_random_mix();
        int lean [10] = '{65, 35, 50, 75, 30, 55, 45, 70, 25, 50};
        int pause [10] = '{30, 0, 60, 15, 0, 40, 25, 0, 50, 0};
        for (int p = 0; p < 10; p++)
        begin
            pause_pct = pause[p];
            for (int k = 0; k < 110; k++)
                random_word(lean[p]);
        end
    endtask

    // Empties the table back to back with no pauses, then checks a read on the empty table.
    task automatic test_drain();
        pause_pct = 0;
        while (shadow_count > 0)
            send_word(OP_REMOVE, ADDR_W'($urandom),
                      INDEX_W'($urandom_range(0, shadow_count - 1)));
        send_word(OP_READ, ADDR_W'($urandom), '0);
    endtask

    initial
    begin : main
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_full_table();
        test_random_mix();
        test_drain();

        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && pending_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sast_pkg.sv
rtl/core/sast_cell.sv
rtl/core/sast_ctrl.sv
rtl/core/sorted_address_set_table_top.sv
test/sorted_address_set_table_top_tb.sv
